@@ hdl/vfvm_pkg.sv @@
// Shared constants, types and address helpers for the voxel face visibility block.
// Used by voxel_face_visibility_mask; depends on nothing else.
package vfvm_pkg;

  // Grid geometry and type width. Sizes are powers of two: coordinates wrap by masking.
  localparam int X_SIZE    = 16;
  localparam int Y_SIZE    = 16;
  localparam int Z_SIZE    = 16;
  localparam int TYPE_BITS = 8;

  localparam int XB = $clog2(X_SIZE);
  localparam int YB = $clog2(Y_SIZE);
  localparam int ZB = $clog2(Z_SIZE);

  localparam int CELL_COUNT = X_SIZE * Y_SIZE * Z_SIZE;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // One plane slot is as large as the biggest face of the grid.
  localparam int PL_YZ   = Y_SIZE * Z_SIZE;
  localparam int PL_XZ   = X_SIZE * Z_SIZE;
  localparam int PL_XY   = X_SIZE * Y_SIZE;
  localparam int PL_M0   = (PL_YZ > PL_XZ) ? PL_YZ : PL_XZ;
  localparam int PL_SIZE = (PL_M0 > PL_XY) ? PL_M0 : PL_XY;
  localparam int SIDE_COUNT = 6;
  localparam int PL_DEPTH   = SIDE_COUNT * PL_SIZE;
  localparam int PL_AW      = $clog2(PL_DEPTH);

  // Clearing sweep covers the larger of the two memories.
  localparam int CLR_COUNT = (CELL_COUNT > PL_DEPTH) ? CELL_COUNT : PL_DEPTH;
  localparam int CLR_W     = $clog2(CLR_COUNT);

  // Operation codes (tuser of the input stream)
  localparam logic [1:0] OP_PLACE = 2'd0;
  localparam logic [1:0] OP_NBR   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_NB_PRESENT  = 2'd0;
  localparam logic [1:0] REG_NB_OCCUPIED = 2'd1;
  localparam logic [1:0] REG_AIR_CODE    = 2'd2;

  typedef logic [TYPE_BITS-1:0] typ_t;

  typedef struct packed {
    logic occ;
    logic opq;
    typ_t typ;
  } cell_t;

  typedef struct packed {
    logic opq;
    typ_t typ;
  } plane_t;

  function automatic logic [CELL_AW-1:0] cell_at(input logic [XB-1:0] x,
                                                 input logic [YB-1:0] y,
                                                 input logic [ZB-1:0] z);
    return CELL_AW'((int'(x) * Y_SIZE + int'(y)) * Z_SIZE + int'(z));
  endfunction

  // Full plane memory address: side slot plus position inside the face.
  function automatic logic [PL_AW-1:0] plane_at(input logic [2:0]    side,
                                                input logic [XB-1:0] x,
                                                input logic [YB-1:0] y,
                                                input logic [ZB-1:0] z);
    int pos;
    if (side < 3'd2) begin
      pos = int'(y) * Z_SIZE + int'(z);
    end else if (side < 3'd4) begin
      pos = int'(x) * Z_SIZE + int'(z);
    end else begin
      pos = int'(x) * Y_SIZE + int'(y);
    end
    return PL_AW'(int'(side) * PL_SIZE + pos);
  endfunction

endpackage

@@ hdl/voxel_face_visibility_mask.sv @@
// Voxel face visibility block: cell grid and neighbor plane memories with a face sequencer.
// Depends on vfvm_pkg.
// Sequence: place, neighbor write and query pass S_RD, S_CEN and S_DONE; a query of an
// occupied cell adds S_FACE (one shared face compare per cycle over six sides) and a clear
// sweeps CLR_COUNT addresses in S_CLR before S_DONE. One item in flight; S_DONE waits for a
// free output register, and ready returns once the result is loaded into it.
// Reset: asynchronous, active low. After release a sweep over CLR_COUNT addresses zeroes
// both memories while s_axis_tready stays low; config writes are taken throughout.
module voxel_face_visibility_mask (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [50:48] neighbor_side,
  // [51] cell_occupied, [52] cell_opaque, [60:53] cell_type, [63:61] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] face_mask, [6] cell_present, [7] chunk_occupied, [8] written, [15:9] zero
  output logic [15:0] m_axis_tdata,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // sequencer states
  localparam logic [2:0] S_INIT = 3'd0;  // sweep after reset
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;  // center cell read in flight
  localparam logic [2:0] S_CEN  = 3'd3;  // center cell available
  localparam logic [2:0] S_FACE = 3'd4;  // neighbor reads + face compare
  localparam logic [2:0] S_CLR  = 3'd5;  // sweep for a clear item
  localparam logic [2:0] S_DONE = 3'd6;  // hand result to output register

  logic [2:0] state_q, state_d;

  // config registers
  logic [5:0] nb_present_q, nb_occ_q;
  logic [7:0] air_q;

  // latched item
  logic [1:0]             op_q;
  logic [vfvm_pkg::XB-1:0] x_q;
  logic [vfvm_pkg::YB-1:0] y_q;
  logic [vfvm_pkg::ZB-1:0] z_q;
  logic [2:0]             side_q;
  logic                   occ_q, opq_q;
  vfvm_pkg::typ_t         typ_q;
  logic [vfvm_pkg::CELL_AW-1:0] idx_q;

  // working state
  logic [vfvm_pkg::CLR_W-1:0] cnt_q;
  logic [2:0]     fk_q;        // side whose reads are issued
  logic           cmp_v_q;     // compare stage holds a side
  logic [2:0]     cmp_side_q;
  logic           is_edge_q;
  vfvm_pkg::typ_t t_q;         // type of queried cell
  logic [5:0]     mask_q;
  logic           present_q, written_q, chunk_q;

  // output register
  logic           mv_q;
  logic [5:0]     out_mask_q;
  logic           out_present_q, out_chunk_q, out_written_q;

  // memories
  vfvm_pkg::cell_t  grid_mem  [vfvm_pkg::CELL_COUNT];
  vfvm_pkg::plane_t plane_mem [vfvm_pkg::PL_DEPTH];
  vfvm_pkg::cell_t  grid_rd_q;
  vfvm_pkg::plane_t plane_rd_q;

  logic                          grid_we, plane_we;
  logic [vfvm_pkg::CELL_AW-1:0]  grid_waddr, grid_raddr;
  logic [vfvm_pkg::PL_AW-1:0]    plane_waddr, plane_raddr;
  vfvm_pkg::cell_t               grid_wdata;
  vfvm_pkg::plane_t              plane_wdata;

  // input unpack and coordinate wrap
  logic [vfvm_pkg::XB-1:0] in_x;
  logic [vfvm_pkg::YB-1:0] in_y;
  logic [vfvm_pkg::ZB-1:0] in_z;
  logic                    in_acc;

  assign in_x   = vfvm_pkg::XB'(s_axis_tdata[15:0] % vfvm_pkg::X_SIZE);
  assign in_y   = vfvm_pkg::YB'(s_axis_tdata[31:16] % vfvm_pkg::Y_SIZE);
  assign in_z   = vfvm_pkg::ZB'(s_axis_tdata[47:32] % vfvm_pkg::Z_SIZE);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Neighbor address generation for side fk_q
  // ---------------------------------------------------------------------------
  logic [vfvm_pkg::XB-1:0] nx;
  logic [vfvm_pkg::YB-1:0] ny;
  logic [vfvm_pkg::ZB-1:0] nz;
  logic                    is_edge;

  always_comb begin
    nx      = x_q;
    ny      = y_q;
    nz      = z_q;
    is_edge = 1'b0;
    unique case (fk_q)
      3'd0: begin
        is_edge = (x_q == vfvm_pkg::XB'(vfvm_pkg::X_SIZE - 1));
        nx      = x_q + 1'b1;
      end
      3'd1: begin
        is_edge = (x_q == '0);
        nx      = x_q - 1'b1;
      end
      3'd2: begin
        is_edge = (y_q == vfvm_pkg::YB'(vfvm_pkg::Y_SIZE - 1));
        ny      = y_q + 1'b1;
      end
      3'd3: begin
        is_edge = (y_q == '0);
        ny      = y_q - 1'b1;
      end
      3'd4: begin
        is_edge = (z_q == vfvm_pkg::ZB'(vfvm_pkg::Z_SIZE - 1));
        nz      = z_q + 1'b1;
      end
      3'd5: begin
        is_edge = (z_q == '0);
        nz      = z_q - 1'b1;
      end
      default: begin
        is_edge = 1'b0;
      end
    endcase
  end

  assign grid_raddr  = (state_q == S_FACE) ? vfvm_pkg::cell_at(nx, ny, nz) : idx_q;
  assign plane_raddr = vfvm_pkg::plane_at(fk_q, x_q, y_q, z_q);

  // ---------------------------------------------------------------------------
  // Shared face compare: one side per cycle
  // ---------------------------------------------------------------------------
  logic face_bit;

  always_comb begin
    if (is_edge_q) begin
      if (!nb_present_q[cmp_side_q]) begin
        face_bit = 1'b0;
      end else if (!nb_occ_q[cmp_side_q]) begin
        face_bit = 1'b1;
      end else begin
        face_bit = !plane_rd_q.opq && (plane_rd_q.typ != t_q);
      end
    end else begin
      face_bit = !(grid_rd_q.opq || (grid_rd_q.typ == t_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Memory write ports
  // ---------------------------------------------------------------------------
  logic sweeping;
  assign sweeping = (state_q == S_INIT) || (state_q == S_CLR);

  always_comb begin
    grid_we     = 1'b0;
    grid_waddr  = idx_q;
    grid_wdata  = '{occ: occ_q, opq: opq_q, typ: typ_q};
    plane_we    = 1'b0;
    plane_waddr = vfvm_pkg::plane_at(side_q, x_q, y_q, z_q);
    plane_wdata = '{opq: opq_q, typ: typ_q};
    if (sweeping) begin
      grid_we     = (int'(cnt_q) < vfvm_pkg::CELL_COUNT);
      grid_waddr  = vfvm_pkg::CELL_AW'(cnt_q);
      grid_wdata  = '0;
      plane_we    = (int'(cnt_q) < vfvm_pkg::PL_DEPTH);
      plane_waddr = vfvm_pkg::PL_AW'(cnt_q);
      plane_wdata = '0;
    end else if (state_q == S_CEN) begin
      grid_we  = (op_q == vfvm_pkg::OP_PLACE) && !grid_rd_q.occ;
      plane_we = (op_q == vfvm_pkg::OP_NBR) && (side_q < 3'(vfvm_pkg::SIDE_COUNT));
    end
  end

  always_ff @(posedge clk_i) begin
    grid_rd_q  <= grid_mem[grid_raddr];
    plane_rd_q <= plane_mem[plane_raddr];
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    if (plane_we) begin
      plane_mem[plane_waddr] <= plane_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_present_q <= '0;
      nb_occ_q     <= '0;
      air_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vfvm_pkg::REG_NB_PRESENT:  nb_present_q <= cfg_data_i[5:0];
        vfvm_pkg::REG_NB_OCCUPIED: nb_occ_q     <= cfg_data_i[5:0];
        vfvm_pkg::REG_AIR_CODE:    air_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !mv_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: if (int'(cnt_q) == vfvm_pkg::CLR_COUNT - 1) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser == vfvm_pkg::OP_CLEAR) ? S_CLR : S_RD;
        end
      end
      S_RD:   state_d = S_CEN;
      S_CEN: begin
        if ((op_q == vfvm_pkg::OP_QUERY) && grid_rd_q.occ) begin
          state_d = S_FACE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FACE: if (fk_q == 3'(vfvm_pkg::SIDE_COUNT)) state_d = S_DONE;
      S_CLR:  if (int'(cnt_q) == vfvm_pkg::CLR_COUNT - 1) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cnt_q     <= '0;
      fk_q      <= '0;
      cmp_v_q   <= 1'b0;
      chunk_q   <= 1'b0;
      mv_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result takes the output slot as the old one leaves
      if ((state_q == S_DONE) && out_free) begin
        mv_q <= 1'b1;
      end else if (mv_q && m_axis_tready) begin
        mv_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT, S_CLR: cnt_q <= cnt_q + 1'b1;
        S_IDLE: begin
          cnt_q <= '0;
          if (in_acc && (s_axis_tuser == vfvm_pkg::OP_CLEAR)) begin
            chunk_q <= 1'b0;
          end
        end
        S_CEN: begin
          fk_q    <= '0;
          cmp_v_q <= 1'b0;
          if ((op_q == vfvm_pkg::OP_PLACE) && !grid_rd_q.occ &&
              (16'(typ_q) != 16'(air_q))) begin
            chunk_q <= 1'b1;
          end
        end
        S_FACE: begin
          fk_q    <= fk_q + 1'b1;
          cmp_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // item and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q      <= s_axis_tuser;
          x_q       <= in_x;
          y_q       <= in_y;
          z_q       <= in_z;
          idx_q     <= vfvm_pkg::cell_at(in_x, in_y, in_z);
          side_q    <= s_axis_tdata[50:48];
          occ_q     <= s_axis_tdata[51];
          opq_q     <= s_axis_tdata[52];
          typ_q     <= vfvm_pkg::typ_t'(s_axis_tdata[60:53]);
          mask_q    <= '0;
          present_q <= 1'b0;
          written_q <= 1'b0;
        end
      end
      S_CEN: begin
        t_q <= grid_rd_q.typ;
        if ((op_q == vfvm_pkg::OP_PLACE) && !grid_rd_q.occ) begin
          written_q <= 1'b1;
          present_q <= occ_q;
        end else begin
          present_q <= grid_rd_q.occ;
        end
      end
      S_FACE: begin
        cmp_side_q <= fk_q;
        is_edge_q  <= is_edge;
        if (cmp_v_q) begin
          mask_q[cmp_side_q] <= face_bit;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_mask_q    <= mask_q;
          out_present_q <= present_q;
          out_chunk_q   <= chunk_q;
          out_written_q <= written_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {7'd0, out_written_q, out_chunk_q, out_present_q, out_mask_q};

endmodule

@@ hdl/vfvm_checker.sv @@
// Port-level checks for voxel_face_visibility_mask, attached by bind.
// Depends on nothing but the top level's ports.
module vfvm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i
);

  // a result waiting for the sink stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // visible faces only on an occupied cell
  a_mask_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[5:0] != 6'd0) |-> m_axis_tdata[6])
    else $error("face mask on unoccupied cell");

  // a place never reports faces
  a_written_nomask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> (m_axis_tdata[5:0] == 6'd0))
    else $error("face mask on a place result");

  // clearing sweep follows reset: no items in or out
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready && !m_axis_tvalid)
    else $error("handshake active right after reset");

endmodule

bind voxel_face_visibility_mask vfvm_checker u_vfvm_checker (.*);

@@ bench/voxel_face_visibility_mask_tb.sv @@
// Self-checking bench for voxel_face_visibility_mask: random and directed item streams.
// Expected results come from a cycle-free model of the grid, planes and registers in here.
// Depends on vfvm_pkg and the block under test.
`timescale 1ns / 1ps

module voxel_face_visibility_mask_tb;

  // Neighbor side codes; the last two are out of range and must be ignored by the block.
  localparam logic [2:0] SIDE_PX     = 3'd0;
  localparam logic [2:0] SIDE_NX     = 3'd1;
  localparam logic [2:0] SIDE_PY     = 3'd2;
  localparam logic [2:0] SIDE_NY     = 3'd3;
  localparam logic [2:0] SIDE_PZ     = 3'd4;
  localparam logic [2:0] SIDE_NZ     = 3'd5;
  localparam logic [2:0] SIDE_BAD_LO = 3'd6;
  localparam logic [2:0] SIDE_BAD_HI = 3'd7;

  // Worst run: ~2000 items plus stalls, a dozen clears and the reset sweep; the limit leaves
  // ample margin.
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_TAIL   = 30;
  localparam int STALL_CYCLES = 200;
  localparam int MAX_REPORTS  = 10;

  // One result item, packed as on m_axis_tdata[8:0]
  typedef struct packed {
    logic       written;
    logic       chunk;
    logic       present;
    logic [5:0] mask;
  } vis_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z, side, occ, opq, type (low to high)
  logic [1:0]  s_axis_tuser = vfvm_pkg::OP_QUERY;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // face_mask, cell_present, chunk_occupied, written
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = vfvm_pkg::REG_NB_PRESENT;
  logic [7:0]  cfg_data_i = '0;

  voxel_face_visibility_mask dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Model state: grid, six boundary planes, chunk flag and the three registers
  // ---------------------------------------------------------------------------------------
  vfvm_pkg::cell_t  vox_grid [vfvm_pkg::CELL_COUNT];
  vfvm_pkg::plane_t face_planes [vfvm_pkg::SIDE_COUNT][vfvm_pkg::PL_SIZE];
  logic        chunk_solid;
  logic [5:0]  nb_present = '0;
  logic [5:0]  nb_occupied = '0;
  logic [7:0]  air_type = '0;

  vis_result_t expected_vis_q[$];
  int          fail_count = 0;
  int          cycle_count = 0;

  // Side and stall control shared with the sink process
  bit          no_idle = 1'b0;
  bit          stall_req = 1'b0;
  int          stall_left = 0;

  // Clear keeps the registers, only storage is emptied
  function automatic void clear_model();
    foreach (vox_grid[i]) vox_grid[i] = '0;
    foreach (face_planes[s, p]) face_planes[s][p] = '0;
    chunk_solid = 1'b0;
  endfunction

  function automatic int grid_index(int x, int y, int z);
    return (x * vfvm_pkg::Y_SIZE + y) * vfvm_pkg::Z_SIZE + z;
  endfunction

  // +x/-x planes are indexed by (y,z), +y/-y by (x,z), +z/-z by (x,y)
  function automatic int face_index(int side, int x, int y, int z);
    if (side < 2) return y * vfvm_pkg::Z_SIZE + z;
    if (side < 4) return x * vfvm_pkg::Z_SIZE + z;
    return x * vfvm_pkg::Y_SIZE + y;
  endfunction

  // Interior face: shows unless the neighbor is opaque or of the same type.
  // A free neighbor still counts through its stored flags.
  function automatic logic inner_open(int idx, vfvm_pkg::typ_t t);
    return !(vox_grid[idx].opq || vox_grid[idx].typ == t);
  endfunction

  // Boundary face: absent chunk hides it, empty chunk shows it, else compare the plane cell
  function automatic logic border_open(int side, int x, int y, int z, vfvm_pkg::typ_t t);
    vfvm_pkg::plane_t p;
    p = face_planes[side][face_index(side, x, y, z)];
    if (!nb_present[side]) return 1'b0;
    if (!nb_occupied[side]) return 1'b1;
    return !p.opq && p.typ != t;
  endfunction

  function automatic vis_result_t predict_visibility(logic [1:0] op, logic [63:0] d);
    int             x, y, z, ci, side;
    logic           occ, opq;
    vfvm_pkg::typ_t typ, t;
    vis_result_t    r;
    x    = int'(d[15:0]) % vfvm_pkg::X_SIZE;
    y    = int'(d[31:16]) % vfvm_pkg::Y_SIZE;
    z    = int'(d[47:32]) % vfvm_pkg::Z_SIZE;
    side = int'(d[50:48]);
    occ  = d[51];
    opq  = d[52];
    typ  = vfvm_pkg::typ_t'(d[60:53]);
    ci   = grid_index(x, y, z);
    r    = '0;
    case (op)
      vfvm_pkg::OP_PLACE: begin
        // only a free cell takes the block, even a free block is stored
        if (!vox_grid[ci].occ) begin
          vox_grid[ci] = '{occ: occ, opq: opq, typ: typ};
          if (int'(typ) != int'(air_type)) chunk_solid = 1'b1;
          r.written = 1'b1;
        end
      end
      vfvm_pkg::OP_NBR: begin
        if (side < vfvm_pkg::SIDE_COUNT) begin
          face_planes[side][face_index(side, x, y, z)] = '{opq: opq, typ: typ};
        end
      end
      vfvm_pkg::OP_QUERY: begin
        if (vox_grid[ci].occ) begin
          t = vox_grid[ci].typ;
          r.mask[SIDE_PX] = (x == vfvm_pkg::X_SIZE - 1) ? border_open(SIDE_PX, x, y, z, t)
                                              : inner_open(grid_index(x + 1, y, z), t);
          r.mask[SIDE_NX] = (x == 0) ? border_open(SIDE_NX, x, y, z, t)
                                     : inner_open(grid_index(x - 1, y, z), t);
          r.mask[SIDE_PY] = (y == vfvm_pkg::Y_SIZE - 1) ? border_open(SIDE_PY, x, y, z, t)
                                              : inner_open(grid_index(x, y + 1, z), t);
          r.mask[SIDE_NY] = (y == 0) ? border_open(SIDE_NY, x, y, z, t)
                                     : inner_open(grid_index(x, y - 1, z), t);
          r.mask[SIDE_PZ] = (z == vfvm_pkg::Z_SIZE - 1) ? border_open(SIDE_PZ, x, y, z, t)
                                              : inner_open(grid_index(x, y, z + 1), t);
          r.mask[SIDE_NZ] = (z == 0) ? border_open(SIDE_NZ, x, y, z, t)
                                     : inner_open(grid_index(x, y, z - 1), t);
        end
      end
      default: clear_model();
    endcase
    // cell and chunk flags are read after the operation took effect
    r.present = vox_grid[ci].occ;
    r.chunk   = chunk_solid;
    return r;
  endfunction

  function automatic logic [63:0] pack_item(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                            logic [2:0] side, logic occ, logic opq,
                                            logic [7:0] typ);
    return {3'b000, typ, opq, occ, side, pz, py, px};
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------
  function automatic void report_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    vis_result_t got, want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got = vis_result_t'(m_axis_tdata[8:0]);
      if (expected_vis_q.size() == 0) begin
        report_fail($sformatf("result %h with nothing expected", m_axis_tdata));
      end else begin
        want = expected_vis_q.pop_front();
        if (got.mask !== want.mask || got.present !== want.present ||
            got.chunk !== want.chunk || got.written !== want.written) begin
          report_fail($sformatf({"mask exp %b got %b, present exp %b got %b, ",
                                 "chunk exp %b got %b, written exp %b got %b"},
                                want.mask, got.mask, want.present, got.present,
                                want.chunk, got.chunk, want.written, got.written));
        end
      end
    end
  end

  // Sink: ~10% random back-pressure, a long hold-off on request, none when no_idle is set
  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------

  // Offer one item; tvalid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(logic [1:0] op, logic [63:0] data);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_vis_q.push_back(predict_visibility(op, data));
  endtask

  // Stop offering and wait until every expected result came back; block is then idle.
  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_vis_q.size() != 0);
  endtask

  task automatic write_regs(logic [5:0] pres, logic [5:0] occd, logic [7:0] air);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{vfvm_pkg::REG_NB_PRESENT, vfvm_pkg::REG_NB_OCCUPIED, vfvm_pkg::REG_AIR_CODE};
    val = '{{2'b00, pres}, {2'b00, occd}, air};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      case (idx[i])
        vfvm_pkg::REG_NB_PRESENT:  nb_present  = val[i][5:0];
        vfvm_pkg::REG_NB_OCCUPIED: nb_occupied = val[i][5:0];
        default:                   air_type    = val[i];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinate near an origin (wrapping), upper bits random; wide picks any value at all
  function automatic logic [15:0] rand_coord(int origin, int size, bit wide);
    int v;
    v = $urandom_range(0, 65535);
    if (!wide) v = v - (v % size) + (origin + $urandom_range(0, 3)) % size;
    return 16'(v);
  endfunction

  function automatic int pick_origin(int size);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return size - 2;   // straddles the high and low boundary
      default: return $urandom_range(0, size - 1);
    endcase
  endfunction

  // Mostly clustered places, plane writes and queries so faces meet neighbors; rare clears.
  task automatic send_random_item(int ox, int oy, int oz);
    int         r;
    bit         wide;
    logic [1:0] op;
    logic [2:0] side;
    logic [7:0] typ;
    r    = $urandom_range(0, 999);
    wide = ($urandom_range(0, 9) == 0);
    if (r < 6)        op = vfvm_pkg::OP_CLEAR;
    else if (r < 360) op = vfvm_pkg::OP_PLACE;
    else if (r < 520) op = vfvm_pkg::OP_NBR;
    else              op = vfvm_pkg::OP_QUERY;
    if ($urandom_range(0, 19) == 0) side = 3'($urandom_range(SIDE_BAD_LO, SIDE_BAD_HI));
    else                            side = 3'($urandom_range(SIDE_PX, SIDE_NZ));
    case ($urandom_range(0, 3))
      0:       typ = air_type;
      1:       typ = 8'd1;
      2:       typ = 8'd2;
      default: typ = 8'($urandom);
    endcase
    send_item(op, pack_item(rand_coord(ox, vfvm_pkg::X_SIZE, wide),
                            rand_coord(oy, vfvm_pkg::Y_SIZE, wide),
                            rand_coord(oz, vfvm_pkg::Z_SIZE, wide), side,
                            $urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)), typ));
  endtask

  task automatic send_random_run(int count);
    int ox, oy, oz;
    for (int i = 0; i < count; i++) begin
      if (i % 90 == 0) begin
        ox = pick_origin(vfvm_pkg::X_SIZE);
        oy = pick_origin(vfvm_pkg::Y_SIZE);
        oz = pick_origin(vfvm_pkg::Z_SIZE);
      end
      send_random_item(ox, oy, oz);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Corners, wrap, every side incl. out-of-range ones, place rules, air code and clear.
  // Registers go in while the post-reset sweep runs: +x,+y,+z chunks occupied, others empty.
  task automatic test_directed_cases();
    write_regs(6'h3F, 6'b010101, 8'h00);
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'hFFFF, 16'h0000, 16'h0000, SIDE_PX, 1'b1, 1'b0, 8'h05));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_NX, 1'b1, 1'b1, 8'hFF));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h0000, 16'hFFFF, 16'h0000, SIDE_PY, 1'b0, 1'b1, 8'h05));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_NY, 1'b1, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h000F, 16'h000F, 16'hFFFF, SIDE_PZ, 1'b1, 1'b0, 8'hFF));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_NZ, 1'b1, 1'b0, 8'h80));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_BAD_LO, 1'b1, 1'b1, 8'h05));
    send_item(vfvm_pkg::OP_NBR,
              pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_BAD_HI, 1'b1, 1'b1, 8'hFF));
    // air block: stored, chunk flag stays low
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_PX, 1'b1, 1'b0, 8'h00));
    // occupied cell refuses a second place
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_PX, 1'b1, 1'b1, 8'h05));
    // free block is written but leaves the cell open
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h0001, 16'h0000, 16'h0000, SIDE_PX, 1'b0, 1'b1, 8'h03));
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h0011, 16'h0000, 16'h0000, SIDE_PX, 1'b1, 1'b0, 8'h07));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_NZ, 1'b1, 1'b1, 8'hFF));
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h000E, 16'h000F, 16'h000F, SIDE_NZ, 1'b1, 1'b0, 8'hFF));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'hFFFE, 16'h001F, 16'h002F, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'h0005, 16'h0005, 16'h0005, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'h0001, 16'h0010, 16'h0000, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_CLEAR,
              pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_BAD_HI, 1'b1, 1'b1, 8'hFF));
    send_item(vfvm_pkg::OP_QUERY,
              pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_PX, 1'b0, 1'b0, 8'h00));
    send_item(vfvm_pkg::OP_PLACE,
              pack_item(16'h0000, 16'h0000, 16'h0000, SIDE_PX, 1'b1, 1'b1, 8'h00));
    finish_stream();
  endtask

  // Five register settings, extremes first; each phase drains before the next write.
  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_regs(6'h3F, 6'h3F, 8'h00);
        1:       write_regs(6'h00, 6'h00, 8'hFF);
        2:       write_regs(6'h3F, 6'h00, 8'($urandom));
        3:       write_regs(6'($urandom), 6'($urandom), 8'h01);
        default: write_regs(6'($urandom), 6'($urandom), 8'($urandom));
      endcase
      send_random_run(360);
      finish_stream();
    end
  endtask

  // Sink holds off for a long stretch while items keep coming: input must back up.
  task automatic test_output_stall();
    stall_req = 1'b1;
    send_random_run(30);
    finish_stream();
  endtask

  // Full-rate stretch, no idling on either side
  task automatic test_steady_stream();
    no_idle = 1'b1;
    send_random_run(150);
    finish_stream();
    no_idle = 1'b0;
  endtask

  initial begin
    clear_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_random_traffic();
    test_output_stall();
    test_steady_stream();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (fail_count == 0 && expected_vis_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
